// ===== hw/rtl/udec_pkg.sv =====
// Shared types, constants and the byte decode function of the UTF-8 stream decoder.
`timescale 1ns / 1ps

package udec_pkg;

  localparam int ByteBits    = 8;
  localparam int RuneBits    = 21;
  localparam int OrdOutBits  = 16;
  localparam int TargetBits  = 16;
  localparam int PendBits    = 2;
  // Width of the internal rune counter; it saturates at its all-ones value.
  localparam int OrdinalBits = 16;

  localparam logic [OrdinalBits-1:0] OrdMax = {OrdinalBits{1'b1}};

  // Lead byte prefixes and the pending counts that they set.
  localparam logic [2:0] Lead2Prefix = 3'b110;
  localparam logic [3:0] Lead3Prefix = 4'b1110;
  localparam logic [4:0] Lead4Prefix = 5'b11110;
  localparam logic [PendBits-1:0] Pend2 = 2'd1;
  localparam logic [PendBits-1:0] Pend3 = 2'd2;
  localparam logic [PendBits-1:0] Pend4 = 2'd3;

  typedef struct packed {
    logic [ByteBits-1:0] byte_in;
    logic                end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [RuneBits-1:0]   code_point;
    logic [OrdOutBits-1:0] rune_ordinal;
    logic                  at_target;
  } result_t;

  typedef struct packed {
    logic [RuneBits-1:0] rune;
    logic [PendBits-1:0] pend;
  } dec_state_t;

  // Next rune and pending count after one byte, before any end-of-string clear.
  function automatic dec_state_t decode_byte(dec_state_t cur, logic [ByteBits-1:0] b);
    dec_state_t nxt;
    nxt = cur;
    if (!b[7]) begin
      nxt.rune = RuneBits'(b);
      nxt.pend = '0;
    end else if (cur.pend != '0) begin
      nxt.rune = {cur.rune[RuneBits-7:0], b[5:0]};
      nxt.pend = cur.pend - PendBits'(1);
    end else if (b[7:5] == Lead2Prefix) begin
      nxt.rune = RuneBits'(b[4:0]);
      nxt.pend = Pend2;
    end else if (b[7:4] == Lead3Prefix) begin
      nxt.rune = RuneBits'(b[3:0]);
      nxt.pend = Pend3;
    end else if (b[7:3] == Lead4Prefix) begin
      nxt.rune = RuneBits'(b[2:0]);
      nxt.pend = Pend4;
    end
    return nxt;
  endfunction

endpackage

// ===== hw/rtl/udec_in_stage.sv =====
// Input register of the UTF-8 stream decoder.
`timescale 1ns / 1ps

module udec_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  udec_pkg::in_item_t in_item_i,
  output logic               item_valid_o,
  output udec_pkg::in_item_t item_o,
  input  logic               advance_i
);
  import udec_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  // The register frees up in the same cycle its item moves on.
  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;
endmodule

// ===== hw/rtl/udec_core.sv =====
// Decode state, rune counter and result formation of the UTF-8 stream decoder.
`timescale 1ns / 1ps

module udec_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  udec_pkg::in_item_t              item_i,
  input  logic                            fire_i,
  input  logic [udec_pkg::TargetBits-1:0] target_i,
  output logic                            emit_o,
  output udec_pkg::result_t               result_o
);
  import udec_pkg::*;

  dec_state_t             st_q, st_d, st_dec;
  logic [OrdinalBits-1:0] cnt_q, cnt_d;

  always_comb begin
    st_dec = decode_byte(st_q, item_i.byte_in);
    emit_o = (st_dec.pend == '0);

    result_o.code_point   = st_dec.rune;
    result_o.rune_ordinal = OrdOutBits'(cnt_q);
    result_o.at_target    = (64'(cnt_q) == 64'(target_i));

    st_d  = st_q;
    cnt_d = cnt_q;
    if (fire_i) begin
      st_d = st_dec;
      if (emit_o && (cnt_q != OrdMax)) begin
        cnt_d = cnt_q + OrdinalBits'(1);
      end
      // The end mark drops any unfinished sequence and restarts the count.
      if (item_i.end_of_string) begin
        st_d  = '0;
        cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '0;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

// ===== hw/rtl/udec_out_stage.sv =====
// Result register of the UTF-8 stream decoder.
`timescale 1ns / 1ps

module udec_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  udec_pkg::result_t result_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output udec_pkg::result_t result_o
);
  import udec_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  // Full means the held item cannot leave in this cycle.
  assign full_o      = valid_q && out_stall_i;
  assign out_valid_o = valid_q;
  assign result_o    = res_q;
endmodule

// ===== hw/rtl/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder.
// Bytes of a UTF-8 string enter one per item on the input channel (in_valid_i, in_stall_o,
// byte_in_i, end_of_string_i). A byte that completes a rune, and also an ASCII byte, a stray
// continuation byte or an F8-FF byte outside a sequence, yields one item on the output
// channel: the rune, its ordinal in the string (saturating) and at_target_o, set when that
// ordinal equals target_index. Lead and continuation bytes inside a sequence yield nothing.
// end_of_string_i on the last byte clears the decode state and the ordinal after that byte.
// target_index is written through cfg_valid_i/cfg_data_i; cfg_ready_o is always high, and
// it should only be written while no item is in flight.
// A byte is first held in the input register and its result is then loaded into the
// result register, which raises out_valid_o. Throughput is one byte per cycle while
// in_stall_o stays low, set by the update of the decode state and the rune counter.
// Reset empties both registers and clears the decode state, the ordinal and target_index.
// When the receiver stalls, the result register holds its item; a further byte that yields
// no result still passes, and one that yields a result waits in the input register, which
// then raises in_stall_o.
`timescale 1ns / 1ps

module utf8_stream_decoder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [udec_pkg::ByteBits-1:0]        byte_in_i,
  input  logic                                 end_of_string_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [udec_pkg::RuneBits-1:0]        code_point_o,
  output logic [udec_pkg::OrdOutBits-1:0]      rune_ordinal_o,
  output logic                                 at_target_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [udec_pkg::TargetBits-1:0]      cfg_data_i
);
  import udec_pkg::*;

  in_item_t              in_item, item;
  logic                  item_valid, advance, emit, out_full;
  result_t               result, out_res;
  logic [TargetBits-1:0] target_q;

  assign in_item.byte_in       = byte_in_i;
  assign in_item.end_of_string = end_of_string_i;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      target_q <= cfg_data_i;
    end
  end

  // An item without a result never waits on the output side.
  assign advance = item_valid && (!emit || !out_full);

  udec_in_stage u_in (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_item_i   (in_item),
    .item_valid_o(item_valid),
    .item_o      (item),
    .advance_i   (advance)
  );

  udec_core u_core (
    .clk_i,
    .rst_ni,
    .item_i  (item),
    .fire_i  (advance),
    .target_i(target_q),
    .emit_o  (emit),
    .result_o(result)
  );

  udec_out_stage u_out (
    .clk_i,
    .rst_ni,
    .load_i     (advance && emit),
    .result_i   (result),
    .full_o     (out_full),
    .out_valid_o,
    .out_stall_i,
    .result_o   (out_res)
  );

  assign code_point_o   = out_res.code_point;
  assign rune_ordinal_o = out_res.rune_ordinal;
  assign at_target_o    = out_res.at_target;
endmodule

// ===== hw/rtl/udec_checker.sv =====
// Port-level assertions for the UTF-8 stream decoder and their bind.
`timescale 1ns / 1ps

module udec_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic [udec_pkg::RuneBits-1:0]        code_point_o,
  input logic [udec_pkg::OrdOutBits-1:0]      rune_ordinal_o,
  input logic                                 at_target_o,
  input logic                                 cfg_valid_i,
  input logic                                 cfg_ready_o,
  input logic [udec_pkg::TargetBits-1:0]      cfg_data_i
);
  import udec_pkg::*;

  logic [TargetBits-1:0] tgt_q;

  // Shadow of the target register as seen on the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tgt_q <= cfg_data_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(code_point_o) && $stable(rune_ordinal_o) && $stable(at_target_o))
    else $error("stalled output item changed");

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty result register");

  a_target_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (at_target_o == (rune_ordinal_o == tgt_q)))
    else $error("at_target disagrees with ordinal and target");

  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");
endmodule

bind utf8_stream_decoder udec_checker u_udec_checker (.*);
